[src/assert_macros.svh]
// Assertion macros shared by the deque RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

[src/bdq_pkg.sv]
// Types and constants for the bounded deque with search.
// No dependencies.
`default_nettype none
package bdq_pkg;
  localparam int unsigned Depth = 16;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned IdxW = $clog2(Depth);

  localparam logic [2:0] OpPushFront = 3'd0;
  localparam logic [2:0] OpPushBack = 3'd1;
  localparam logic [2:0] OpPopFront = 3'd2;
  localparam logic [2:0] OpPopBack = 3'd3;
  localparam logic [2:0] OpRead = 3'd4;
  localparam logic [2:0] OpWrite = 3'd5;
  localparam logic [2:0] OpDelete = 3'd6;
  localparam logic [2:0] OpDedup = 3'd7;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StMiss = 2'd2;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic load_front; // shift toward back, cell 0 takes the new value
    logic drop_front; // shift toward front
    logic [IdxW-1:0] wr_idx;
    logic wr_en;
    logic [31:0] wr_val;
    logic [IdxW-1:0] rm_idx; // cells at or after rm_idx take their back neighbor
    logic rm_en;
  } cell_ctrl_t;
endpackage
`default_nettype wire

[src/bdq_cell.sv]
// One storage cell of the deque chain.
// Depends on bdq_pkg.
`default_nettype none
module bdq_cell
  import bdq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [IdxW-1:0] idx_i,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire logic [31:0]     prev_i,
  input  wire logic [31:0]     next_i,
  output logic [31:0]          val_o
);
  logic [31:0] val_q, val_d;
  always_comb begin
    val_d = val_q;
    if (ctrl_i.load_front) begin
      val_d = prev_i;
    end else if (ctrl_i.drop_front) begin
      val_d = next_i;
    end else if (ctrl_i.rm_en && idx_i >= ctrl_i.rm_idx) begin
      val_d = next_i;
    end else if (ctrl_i.wr_en && idx_i == ctrl_i.wr_idx) begin
      val_d = ctrl_i.wr_val;
    end
  end
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end
  assign val_o = val_q;
  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule
`default_nettype wire

[src/bounded_deque_with_search_unit.sv]
// Top level of the bounded deque with search: control sequencer and a chain of cells.
// Depends on bdq_pkg, bdq_cell and assert_macros.svh.
// Usage: one request item enters on s_axis (tdata: opcode[2:0], data_value[34:3],
// position[42:35]); one result item leaves on m_axis (tdata: read_value[31:0],
// entry_count[36:32], min_value[68:37], max_value[100:69], status[102:101]).
// Entries sit in a row of cells, entry 1 in cell 0; push front and pop front shift
// the whole row at once. After the operation a scan walks the cells one per cycle
// to form min and max. Delete walks the row once more to find the entry, and
// dedup takes one pass of up to count steps per entry, each step one compare.
// One item is in work at a time; s_axis_tready is high only when idle and the
// result register is free. Reset empties the store; while the receiver stalls
// the result holds and no new item is taken.
`default_nettype none
`include "assert_macros.svh"
module bounded_deque_with_search_unit
  import bdq_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [47:0]  s_axis_tdata,  // opcode, data_value, position
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata   // read_value, entry_count, min, max, status
);
  localparam logic [2:0] SIdle = 3'd0, SSearch = 3'd1, SDedup = 3'd2, SScan = 3'd3,
    SOut = 3'd4;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0] val_q, val_d, rd_q, rd_d, lo_q, lo_d, hi_q, hi_d;
  logic [1:0] st_q, st_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d, w_q, w_d;
  logic [31:0] cells [Depth];
  cell_ctrl_t ctrl;

  logic [2:0] in_op;
  logic [31:0] in_val;
  logic [7:0] in_pos;
  assign in_op = s_axis_tdata[2:0];
  assign in_val = s_axis_tdata[34:3];
  assign in_pos = s_axis_tdata[42:35];
  logic [4:0] unused_pad;
  assign unused_pad = s_axis_tdata[47:43];

  assign s_axis_tready = (state_q == SIdle);
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  genvar g;
  for (g = 0; g < Depth; g++) begin : g_cell
    logic [31:0] prev_v, next_v;
    assign prev_v = (g == 0) ? in_val : cells[(g == 0) ? 0 : g - 1];
    assign next_v = (g == Depth - 1) ? 32'd0 : cells[(g == Depth - 1) ? g : g + 1];
    bdq_cell u_cell (
      .clk_i, .rst_ni, .idx_i(IdxW'(g)), .ctrl_i(ctrl),
      .prev_i(prev_v), .next_i(next_v), .val_o(cells[g])
    );
  end

  logic [31:0] ci, cj;
  assign ci = cells[i_q[IdxW-1:0]];
  assign cj = cells[j_q[IdxW-1:0]];

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; val_d = val_q; rd_d = rd_q;
    lo_d = lo_q; hi_d = hi_q; st_d = st_q; i_d = i_q; j_d = j_q; w_d = w_q;
    ctrl = '0;
    ctrl.wr_val = val_q;
    unique case (state_q)
      SIdle: begin
        if (acc) begin
          val_d = in_val; rd_d = '0; st_d = StOk;
          i_d = '0; j_d = '0; w_d = '0; state_d = SScan;
          unique case (in_op)
            OpPushFront, OpPushBack: begin
              if (cnt_q == CntW'(Depth)) begin
                st_d = StFull;
              end else begin
                cnt_d = cnt_q + 1'b1;
                if (in_op == OpPushFront) begin
                  ctrl.load_front = 1'b1;
                end else begin
                  ctrl.wr_en = 1'b1; ctrl.wr_val = in_val;
                  ctrl.wr_idx = cnt_q[IdxW-1:0];
                end
              end
            end
            OpPopFront, OpPopBack: begin
              if (cnt_q == '0) begin
                st_d = StMiss;
              end else begin
                cnt_d = cnt_q - 1'b1;
                if (in_op == OpPopFront) begin
                  rd_d = cells[0]; ctrl.drop_front = 1'b1;
                end else begin
                  rd_d = cells[IdxW'(cnt_q - 1'b1)];
                end
              end
            end
            OpRead, OpWrite: begin
              if (in_pos == '0 || {1'b0, in_pos} > 9'(cnt_q)) begin
                st_d = StMiss;
              end else if (in_op == OpRead) begin
                rd_d = cells[IdxW'(in_pos - 8'd1)];
              end else begin
                ctrl.wr_en = 1'b1; ctrl.wr_val = in_val;
                ctrl.wr_idx = IdxW'(in_pos - 8'd1);
              end
            end
            OpDelete: state_d = SSearch;
            default: state_d = SDedup;
          endcase
        end
      end
      SSearch: begin
        if (i_q == cnt_q) begin
          st_d = StMiss; i_d = '0; state_d = SScan;
        end else if (ci == val_q) begin
          ctrl.rm_en = 1'b1; ctrl.rm_idx = i_q[IdxW-1:0];
          cnt_d = cnt_q - 1'b1; i_d = '0; state_d = SScan;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      SDedup: begin
        // i: read index, j: compare index below w, w: kept entries.
        if (i_q == cnt_q) begin
          cnt_d = w_q; i_d = '0; state_d = SScan;
        end else if (j_q == w_q) begin
          ctrl.wr_en = 1'b1; ctrl.wr_val = ci; ctrl.wr_idx = w_q[IdxW-1:0];
          w_d = w_q + 1'b1; i_d = i_q + 1'b1; j_d = '0;
        end else if (cj == ci) begin
          i_d = i_q + 1'b1; j_d = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      SScan: begin
        if (i_q == cnt_q) begin
          if (cnt_q == '0) begin
            lo_d = '0; hi_d = '0;
          end
          state_d = SOut;
        end else begin
          if (i_q == '0 || $signed(ci) < $signed(lo_q)) lo_d = ci;
          if (i_q == '0 || $signed(ci) > $signed(hi_q)) hi_d = ci;
          i_d = i_q + 1'b1;
        end
      end
      SOut: begin
        if (m_axis_tready) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    val_q <= val_d; rd_q <= rd_d; lo_q <= lo_d; hi_q <= hi_d;
    st_q <= st_d; i_q <= i_d; j_q <= j_d; w_q <= w_d;
  end

  assign m_axis_tvalid = (state_q == SOut);
  assign m_axis_tdata = {1'b0, st_q, hi_q, lo_q, 5'(cnt_q), rd_q};

  `ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, cnt_q <= CntW'(Depth), "count above depth")
  `ASSERT_IMPL(a_out_idle, clk_i, rst_ni, !(m_axis_tvalid && s_axis_tready), "ready in output")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
    "result dropped")
endmodule
`default_nettype wire
